// ===== rtl/copp_pkg.sv =====
// Shared types, constants and the divider step for the color opponency pipeline.
// Depends on nothing; every other file in rtl imports it.
package copp_pkg;

	localparam int PIX_W   = 8;   // width of one color component
	localparam int SUM_W   = 10;  // b + g + r, at most 765
	localparam int NUM_W   = 23;  // clamped difference scaled to Q1.15 numerator
	localparam int Q_W     = 16;  // quotient width, at most 32768
	localparam int LANES   = 4;   // red, green, blue, yellow
	localparam int STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES      = Q_W / STEPS_PER_STAGE;

	localparam int LANE_RED    = 0;
	localparam int LANE_GREEN  = 1;
	localparam int LANE_BLUE   = 2;
	localparam int LANE_YELLOW = 3;

	// floor(x / 3) == (x * RECIP3) >> RECIP3_SHIFT for every x below 2**16.
	localparam logic [15:0] RECIP3       = 16'd43691;
	localparam int          RECIP3_SHIFT = 17;
	// floor(256 s / 3) == 85 s + floor(s / 3).
	localparam logic [6:0]  INTENS_MUL   = 7'd85;

	typedef struct packed {
		logic [PIX_W-1:0] blue_in;
		logic [PIX_W-1:0] green_in;
		logic [PIX_W-1:0] red_in;
	} pixel_t;

	typedef struct packed {
		logic [Q_W-1:0] red_opponent;
		logic [Q_W-1:0] green_opponent;
		logic [Q_W-1:0] blue_opponent;
		logic [Q_W-1:0] yellow_opponent;
		logic [Q_W-1:0] intensity_level;
	} result_t;

	// One divider lane: the partial remainder, and a word that holds the
	// numerator bits still to be consumed above the quotient bits found so far.
	typedef struct packed {
		logic [SUM_W-1:0] rem;
		logic [Q_W-1:0]   work;
	} lane_t;

	typedef struct packed {
		lane_t [LANES-1:0] lane;
		logic [SUM_W-1:0]  sum;
		logic [PIX_W-1:0]  third;  // floor(sum / 3)
	} div_t;

	// One restoring division step. The remainder is always below the divisor,
	// so the shifted remainder stays below twice the divisor.
	function automatic lane_t div_step(input lane_t l, input logic [SUM_W-1:0] d);
		logic [SUM_W:0] r2;
		logic [SUM_W:0] diff;
		lane_t          n;
		r2     = {l.rem, l.work[Q_W-1]};
		diff   = r2 - {1'b0, d};
		n.work = {l.work[Q_W-2:0], 1'b0};
		if (r2 >= {1'b0, d}) begin
			n.rem     = diff[SUM_W-1:0];
			n.work[0] = 1'b1;
		end else begin
			n.rem = r2[SUM_W-1:0];
		end
		return n;
	endfunction

endpackage

// ===== rtl/copp_front.sv =====
// First pipeline stage: component sum, clamped differences, divider lane setup, sum / 3.
// Depends on copp_pkg.
module copp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_stall,
	input  copp_pkg::pixel_t  up_data,
	output logic              dn_valid,
	input  logic              dn_stall,
	output copp_pkg::div_t    dn_data
);
	import copp_pkg::*;

	logic                 vld_s1;
	div_t                 data_s1;
	div_t                 nxt;
	logic [SUM_W-1:0]     sum;
	logic signed [SUM_W:0] d_red;
	logic signed [SUM_W:0] d_green;
	logic signed [SUM_W:0] d_blue;
	logic signed [SUM_W:0] d_yel;
	logic [PIX_W-1:0]     min_rg;
	logic [SUM_W+15:0]    prod3;
	logic [NUM_W-1:0]     num [LANES];

	always_comb begin
		sum = SUM_W'(up_data.blue_in) + SUM_W'(up_data.green_in) + SUM_W'(up_data.red_in);
		min_rg = (up_data.red_in < up_data.green_in) ? up_data.red_in : up_data.green_in;
		d_red   = $signed({2'b0, up_data.red_in, 1'b0}) - $signed({3'b0, up_data.blue_in})
			- $signed({3'b0, up_data.green_in});
		d_green = $signed({2'b0, up_data.green_in, 1'b0}) - $signed({3'b0, up_data.blue_in})
			- $signed({3'b0, up_data.red_in});
		d_blue  = $signed({2'b0, up_data.blue_in, 1'b0}) - $signed({3'b0, up_data.red_in})
			- $signed({3'b0, up_data.green_in});
		d_yel   = $signed({3'b0, min_rg}) - $signed({3'b0, up_data.blue_in});
		// Negative differences clamp to zero; a zero numerator yields a zero quotient.
		num[LANE_RED]    = d_red[SUM_W]   ? '0 : {d_red[8:0], 14'b0};
		num[LANE_GREEN]  = d_green[SUM_W] ? '0 : {d_green[8:0], 14'b0};
		num[LANE_BLUE]   = d_blue[SUM_W]  ? '0 : {d_blue[8:0], 14'b0};
		num[LANE_YELLOW] = d_yel[SUM_W]   ? '0 : {d_yel[7:0], 15'b0};
		for (int i = 0; i < LANES; i++) begin
			nxt.lane[i].rem  = {3'b0, num[i][NUM_W-1:Q_W]};
			nxt.lane[i].work = num[i][Q_W-1:0];
		end
		prod3     = sum * RECIP3;
		nxt.sum   = sum;
		nxt.third = prod3[RECIP3_SHIFT+PIX_W-1:RECIP3_SHIFT];
	end

	assign up_stall = vld_s1 && dn_stall;
	assign dn_valid = vld_s1;
	assign dn_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!up_stall) begin
			vld_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && !up_stall) begin
			data_s1 <= nxt;
		end
	end

endmodule

// ===== rtl/copp_div_stage.sv =====
// One divider stage: two quotient bits for each of the four lanes.
// Depends on copp_pkg.
module copp_div_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_stall,
	input  copp_pkg::div_t  up_data,
	output logic            dn_valid,
	input  logic            dn_stall,
	output copp_pkg::div_t  dn_data
);
	import copp_pkg::*;

	logic vld_s1;
	div_t data_s1;
	div_t nxt;

	always_comb begin
		nxt = up_data;
		for (int i = 0; i < LANES; i++) begin
			for (int k = 0; k < STEPS_PER_STAGE; k++) begin
				nxt.lane[i] = div_step(nxt.lane[i], up_data.sum);
			end
		end
	end

	assign up_stall = vld_s1 && dn_stall;
	assign dn_valid = vld_s1;
	assign dn_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!up_stall) begin
			vld_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && !up_stall) begin
			data_s1 <= nxt;
		end
	end

endmodule

// ===== rtl/copp_out.sv =====
// Output stage: black-pixel masking, intensity, and the result register.
// Depends on copp_pkg.
module copp_out (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_stall,
	input  copp_pkg::div_t     up_data,
	output logic               dn_valid,
	input  logic               dn_stall,
	output copp_pkg::result_t  dn_data
);
	import copp_pkg::*;

	logic          vld_s1;
	result_t       data_s1;
	result_t       nxt;
	logic          black;
	logic [16:0]   inten;

	always_comb begin
		// A black pixel divides by zero; its lanes hold all ones and are dropped.
		black = (up_data.sum == '0);
		inten = 17'(up_data.sum) * 17'(INTENS_MUL) + 17'(up_data.third);
		nxt.red_opponent    = black ? '0 : up_data.lane[LANE_RED].work;
		nxt.green_opponent  = black ? '0 : up_data.lane[LANE_GREEN].work;
		nxt.blue_opponent   = black ? '0 : up_data.lane[LANE_BLUE].work;
		nxt.yellow_opponent = black ? '0 : up_data.lane[LANE_YELLOW].work;
		nxt.intensity_level = inten[Q_W-1:0];
	end

	assign up_stall = vld_s1 && dn_stall;
	assign dn_valid = vld_s1;
	assign dn_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!up_stall) begin
			vld_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && !up_stall) begin
			data_s1 <= nxt;
		end
	end

endmodule

// ===== rtl/color_opponency_split_top.sv =====
// Top level of the broadly tuned color channel pipeline.
// Depends on copp_pkg, copp_front, copp_div_stage and copp_out.
//
// This block turns one 8-bit blue, green, red pixel into four color channels
// (red, green, blue, yellow), each a clamped difference divided by the
// component sum and given as a truncated Q1.15 fraction, plus the mean
// intensity in Q8.8. A black pixel gives all zeros. The block takes one pixel
// every clock cycle while pixel_stall is low. Four parallel restoring
// dividers resolve each 16-bit quotient two bits per stage over eight stages,
// framed by one setup stage (sum, differences, reciprocal multiply for the
// intensity) and one output register. Every stage holds its own valid bit, so
// a stall at the output fills empty stages first and only then holds off new
// requests; nothing is dropped or repeated.
module color_opponency_split_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pixel_valid,
	output logic               pixel_stall,
	input  copp_pkg::pixel_t   pixel,
	output logic               chan_valid,
	input  logic               chan_stall,
	output copp_pkg::result_t  chan
);
	import copp_pkg::*;

	// Link k joins the stage before it to the stage after it; link 0 leaves the
	// setup stage and the last link feeds the output register.
	logic vld   [DIV_STAGES+1];
	logic stl   [DIV_STAGES+1];
	div_t dat   [DIV_STAGES+1];

	copp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (pixel_valid),
		.up_stall (pixel_stall),
		.up_data  (pixel),
		.dn_valid (vld[0]),
		.dn_stall (stl[0]),
		.dn_data  (dat[0])
	);

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		copp_div_stage u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (vld[k]),
			.up_stall (stl[k]),
			.up_data  (dat[k]),
			.dn_valid (vld[k+1]),
			.dn_stall (stl[k+1]),
			.dn_data  (dat[k+1])
		);
	end

	copp_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (vld[DIV_STAGES]),
		.up_stall (stl[DIV_STAGES]),
		.up_data  (dat[DIV_STAGES]),
		.dn_valid (chan_valid),
		.dn_stall (chan_stall),
		.dn_data  (chan)
	);

	// New requests are held off only when every stage is full behind a stalled output.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> (chan_valid && chan_stall))
		else $error("input stalled while the pipeline has room");

	// Zero intensity means a black pixel, whose color channels must all be zero.
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(chan_valid && chan.intensity_level == '0) |->
		(chan.red_opponent == '0 && chan.green_opponent == '0 &&
		 chan.blue_opponent == '0 && chan.yellow_opponent == '0))
		else $error("black pixel produced a nonzero color channel");

	// Quotients stay within their ranges; a slip in the divider shows up as overflow.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		chan_valid |->
		(chan.red_opponent <= 16'd32768 && chan.green_opponent <= 16'd32768 &&
		 chan.blue_opponent <= 16'd32768 && chan.yellow_opponent <= 16'd16384))
		else $error("color channel out of range");

	// The three differences sum to zero, so they cannot all be positive.
	a_not_all: assert property (@(posedge clk) disable iff (!arst_n)
		chan_valid |->
		!(chan.red_opponent != '0 && chan.green_opponent != '0 && chan.blue_opponent != '0))
		else $error("red, green and blue channels all positive");

endmodule

// ===== verif/copp_channel_checker.sv =====
// Checker for the color opponency pipeline: watches the request and result channels,
// predicts each result and compares it field by field.
// Depends on copp_pkg for the pixel and result types.
module copp_channel_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pixel_valid,
	input  logic              pixel_stall,
	input  copp_pkg::pixel_t  pixel,
	input  logic              chan_valid,
	input  logic              chan_stall,
	input  copp_pkg::result_t chan,
	output int                fail_count,
	output int                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import copp_pkg::*;

	localparam int HALF_SCALE = 16384;
	localparam int FULL_SCALE = 32768;
	localparam int Q88_SCALE  = 256;

	result_t expected_channels[$];
	result_t want;

	function automatic int clamped_share(input int diff, input int scale, input int sum);
		if (diff <= 0 || sum == 0)
			return 0;
		return diff * scale / sum;
	endfunction

	// A black pixel falls out as all zeros: every difference and the sum are zero.
	function automatic result_t predict_channels(input pixel_t p);
		int      b, g, r, s, lo;
		result_t e;
		b  = p.blue_in;
		g  = p.green_in;
		r  = p.red_in;
		s  = b + g + r;
		lo = (r < g) ? r : g;
		e.red_opponent    = 16'(clamped_share(2 * r - b - g, HALF_SCALE, s));
		e.green_opponent  = 16'(clamped_share(2 * g - b - r, HALF_SCALE, s));
		e.blue_opponent   = 16'(clamped_share(2 * b - r - g, HALF_SCALE, s));
		e.yellow_opponent = 16'(clamped_share(lo - b, FULL_SCALE, s));
		e.intensity_level = 16'(s * Q88_SCALE / 3);
		return e;
	endfunction

	task automatic check_field(input string label, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			fail_count++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d",
				$time, label, exp_val, act_val);
		end
	endtask

	// Reset is applied once at the start of the run, which also clears the count.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_channels.delete();
			fail_count  = 0;
			outstanding = 0;
		end else begin
			if (pixel_valid && !pixel_stall)
				expected_channels.push_back(predict_channels(pixel));
			if (chan_valid && !chan_stall) begin
				if (expected_channels.size() == 0) begin
					fail_count++;
					$display("%0t ns: result with no request pending, expected none, actual %h",
						$time, chan);
				end else begin
					want = expected_channels.pop_front();
					check_field("red_opponent", want.red_opponent, chan.red_opponent);
					check_field("green_opponent", want.green_opponent, chan.green_opponent);
					check_field("blue_opponent", want.blue_opponent, chan.blue_opponent);
					check_field("yellow_opponent", want.yellow_opponent,
						chan.yellow_opponent);
					check_field("intensity_level", want.intensity_level,
						chan.intensity_level);
				end
			end
			outstanding = expected_channels.size();
		end
	end

endmodule

// ===== verif/tb_color_opponency_split_top.sv =====
// Testbench top for color_opponency_split_top: clock, reset, pixel stimulus,
// output back-pressure and the final verdict.
// Depends on copp_pkg, the block itself and copp_channel_checker.
module tb_color_opponency_split_top;
	timeunit 1ns;
	timeprecision 1ps;
	import copp_pkg::*;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    pixel_valid;
	logic    pixel_stall;
	pixel_t  pixel;
	logic    chan_valid;
	logic    chan_stall;
	result_t chan;
	int      fail_count;
	int      outstanding;

	// Percentages of cycles in which the pixel source holds off a request and
	// in which the result sink stalls. They change between the test phases.
	int send_idle_pct;
	int recv_stall_pct;

	// Corner pixels, packed as blue, green, red from the top byte down.
	localparam logic [23:0] CORNER_PIXELS [16] = '{
		24'h000000,  // black pixel: everything must come out zero
		24'hFFFFFF,  // white: all colour channels clamp to zero
		24'h0000FF,  // pure red, red channel at full scale
		24'h00FF00,  // pure green
		24'hFF0000,  // pure blue
		24'h00FFFF,  // pure yellow, yellow channel at its ceiling
		24'hFFFF00,  // cyan
		24'hFF00FF,  // magenta
		24'h000001,  // smallest nonzero sum, red only
		24'h000100,  // smallest nonzero sum, green only
		24'h010000,  // smallest nonzero sum, blue only
		24'h000101,  // dim yellow
		24'h7F7F7F,  // mid gray
		24'h8040C0,
		24'h01FEFF,
		24'hFF0101
	};

	always #10 clk = ~clk;

	color_opponency_split_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.chan_valid  (chan_valid),
		.chan_stall  (chan_stall),
		.chan        (chan)
	);

	copp_channel_checker chk_channels (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.chan_valid  (chan_valid),
		.chan_stall  (chan_stall),
		.chan        (chan),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// The sink decides its stall afresh at every falling edge, so stalls come
	// regardless of how full the pipeline is.
	always @(negedge clk) begin
		chan_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Random pixels drawn from several families. Plain uniform pixels rarely
	// hit the clamp boundaries or tiny sums, so those get their own share.
	function automatic pixel_t random_pixel();
		int     roll;
		int     v;
		pixel_t p;
		roll = $urandom_range(99);
		p.blue_in  = 8'($urandom_range(255));
		p.green_in = 8'($urandom_range(255));
		p.red_in   = 8'($urandom_range(255));
		if (roll >= 40 && roll < 55) begin
			// Components at or next to the range ends.
			p.blue_in  = {{7{$urandom_range(1) == 1}}, 1'($urandom_range(1))};
			p.green_in = {{7{$urandom_range(1) == 1}}, 1'($urandom_range(1))};
			p.red_in   = {{7{$urandom_range(1) == 1}}, 1'($urandom_range(1))};
		end else if (roll >= 55 && roll < 67) begin
			// Near-gray: differences sit around zero, where the clamp acts.
			v = $urandom_range(1, 254);
			p.blue_in  = 8'(v + $urandom_range(2) - 1);
			p.green_in = 8'(v + $urandom_range(2) - 1);
			p.red_in   = 8'(v + $urandom_range(2) - 1);
		end else if (roll >= 67 && roll < 82) begin
			// One strong component over two weak ones, or two strong (yellowish).
			p.blue_in  = 8'($urandom_range(40));
			p.green_in = 8'($urandom_range(40));
			p.red_in   = 8'($urandom_range(40));
			case ($urandom_range(3))
				0: p.blue_in = 8'($urandom_range(200, 255));
				1: p.green_in = 8'($urandom_range(200, 255));
				2: p.red_in = 8'($urandom_range(200, 255));
				default: begin
					p.green_in = 8'($urandom_range(200, 255));
					p.red_in   = 8'($urandom_range(200, 255));
				end
			endcase
		end else if (roll >= 82 && roll < 95) begin
			// Very dim pixels: small divisors stress the quotient range.
			p.blue_in  = 8'($urandom_range(3));
			p.green_in = 8'($urandom_range(3));
			p.red_in   = 8'($urandom_range(3));
		end else if (roll >= 95) begin
			p = '0;
		end
		return p;
	endfunction

	// Offers one request and returns at the falling edge after it is taken.
	// It is entered at a falling edge. Each cycle before the offer idles with
	// the set chance. While the source idles the payload is scrambled, which
	// the block must ignore since valid is low.
	task automatic send_pixel(input pixel_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			pixel       <= pixel_t'(24'($urandom));
			@(negedge clk);
		end
		pixel_valid <= 1'b1;
		pixel       <= p;
		do
			@(posedge clk);
		while (pixel_stall);
		@(negedge clk);
	endtask

	// Holds off the source until every result that was asked for has arrived.
	// It always lets at least one falling edge pass so that valid is not
	// lowered and raised again in one time step.
	task automatic drain_results();
		pixel_valid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
	endtask

	task automatic run_random(input int count);
		repeat (count)
			send_pixel(random_pixel());
	endtask

	initial begin
		pixel_valid    = 1'b0;
		pixel          = '0;
		arst_n         = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Phase one: a rarely idle source against a sink that stalls most of
		// the time, so the pipeline fills and the input stall gets exercised.
		send_idle_pct  = 14;
		recv_stall_pct = 85;
		foreach (CORNER_PIXELS[i])
			send_pixel(pixel_t'(CORNER_PIXELS[i]));
		drain_results();
		run_random(270);
		drain_results();

		// Phase two: a sparse source against an eager sink, leaving bubbles
		// between requests all through the pipeline.
		send_idle_pct  = 85;
		recv_stall_pct = 14;
		run_random(270);
		drain_results();

		// Phase three: full rate on both sides, one pixel per clock.
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random(260);
		drain_results();

		// Give the block time to show any stray result before the verdict.
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog: far beyond the length of a correct run, so only a hung
	// handshake reaches it.
	initial begin
		#5000000;
		$display("Verification failed");
		$finish;
	end

endmodule
